>>> rtl/core/gfbr_pkg.sv
// Package for the gated FIFO with burst release.
// Holds the channel payload structs, the result kinds and the front-to-back command.
// No dependencies.
package gfbr_pkg;

  localparam int ID_W       = 32;  // identifier width on both channels
  localparam int WAIT_W     = 7;   // width of the waiting count in a result
  localparam int BURST_W    = 7;   // width of the burst_size register
  localparam int RESULT_CAP = 64;  // most results one toggle may cause

  // Result kinds, also used as command opcodes
  typedef enum logic [2:0] {
    KIND_PASSED      = 3'd0,
    KIND_QUEUED      = 3'd1,
    KIND_DROPPED     = 3'd2,
    KIND_RELEASED    = 3'd3,
    KIND_CLOSED      = 3'd4,
    KIND_OPENED_NONE = 3'd5
  } kind_t;

  typedef struct packed {
    logic            action;
    logic [ID_W-1:0] vehicle_id;
  } in_item_t;

  typedef struct packed {
    kind_t             kind;
    logic [ID_W-1:0]   item_id;
    logic              gate_open;
    logic [WAIT_W-1:0] waiting;
    logic              last;
  } out_item_t;

  // Classified command handed from front to back. For a release, waiting is
  // the fill count before the burst and count_n the number of entries to drain.
  typedef struct packed {
    kind_t              op;
    logic [ID_W-1:0]    id;
    logic               gate_after;
    logic [WAIT_W-1:0]  waiting;
    logic [BURST_W-1:0] count_n;
  } cmd_t;

  typedef enum logic {
    BK_IDLE,
    BK_RELEASE
  } back_state_t;

endpackage

>>> rtl/core/gfbr_front.sv
// Front end: accepts input beats, tracks the gate and the fill count, and
// classifies each beat into a command for the back end. Uses gfbr_pkg.
module gfbr_front import gfbr_pkg::*; #(
  parameter int QUEUE_DEPTH = 64
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  in_item_t           in_data,
  input  logic               cfg_valid,
  input  logic [BURST_W-1:0] cfg_data,
  input  logic               cmd_full,
  output logic               cmd_push,
  output cmd_t               cmd_data
);

  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam int MW = (CW > WAIT_W) ? CW : WAIT_W;

  logic               gate_r, gate_nxt;
  logic [CW-1:0]      count_r, count_nxt;
  logic [BURST_W-1:0] burst_r;

  logic [MW-1:0]      count_ext;
  logic [MW-1:0]      count_inc;
  logic [BURST_W-1:0] cap_burst;
  logic [BURST_W-1:0] n_rel;
  logic [MW-1:0]      count_dec;

  assign in_ready = !cmd_full;
  assign cmd_push = in_valid && in_ready;

  assign count_ext = MW'(count_r);
  assign count_inc = count_ext + MW'(1);
  // limit the burst to the per-toggle cap, then to what is queued
  assign cap_burst = (burst_r > BURST_W'(RESULT_CAP)) ? BURST_W'(RESULT_CAP) : burst_r;
  assign n_rel     = (count_ext < MW'(cap_burst)) ? BURST_W'(count_ext) : cap_burst;
  assign count_dec = count_ext - MW'(n_rel);

  // Classify the beat and work out the gate and count it leaves behind
  always_comb begin
    gate_nxt            = gate_r;
    count_nxt           = count_r;
    cmd_data.op         = KIND_PASSED;
    cmd_data.id         = in_data.vehicle_id;
    cmd_data.gate_after = gate_r;
    cmd_data.waiting    = count_ext[WAIT_W-1:0];
    cmd_data.count_n    = '0;
    if (!in_data.action) begin
      if (gate_r) begin
        cmd_data.op = KIND_PASSED;
      end else if (count_ext >= MW'(QUEUE_DEPTH)) begin
        cmd_data.op = KIND_DROPPED;
      end else begin
        cmd_data.op      = KIND_QUEUED;
        cmd_data.waiting = count_inc[WAIT_W-1:0];
        count_nxt        = CW'(count_inc);
      end
    end else begin
      cmd_data.id = '0;
      if (gate_r) begin
        cmd_data.op         = KIND_CLOSED;
        cmd_data.gate_after = 1'b0;
        gate_nxt            = 1'b0;
      end else if (n_rel == '0) begin
        cmd_data.op         = KIND_OPENED_NONE;
        cmd_data.gate_after = 1'b1;
        gate_nxt            = 1'b1;
      end else begin
        cmd_data.op         = KIND_RELEASED;
        cmd_data.gate_after = 1'b0;
        cmd_data.count_n    = n_rel;
        count_nxt           = CW'(count_dec);
      end
    end
  end

  // Advance gate and count on each accepted beat; take register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gate_r  <= 1'b0;
      count_r <= '0;
      burst_r <= '0;
    end else begin
      if (cmd_push) begin
        gate_r  <= gate_nxt;
        count_r <= count_nxt;
      end
      if (cfg_valid) begin
        burst_r <= cfg_data;
      end
    end
  end

endmodule

>>> rtl/core/gfbr_cmd_fifo.sv
// Two-entry command queue between front and back end.
// Uses gfbr_pkg for the command struct.
module gfbr_cmd_fifo import gfbr_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  cmd_t push_data,
  output logic full,
  input  logic pop,
  output logic cmd_valid,
  output cmd_t cmd_data
);

  cmd_t       entry_r [2];
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  logic [1:0] cnt_r;

  assign full      = (cnt_r == 2'd2);
  assign cmd_valid = (cnt_r != 2'd0);
  assign cmd_data  = entry_r[rd_ptr_r];

  // Hold the entries
  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_data;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (push) wr_ptr_r <= !wr_ptr_r;
      if (pop)  rd_ptr_r <= !rd_ptr_r;
      unique case ({push, pop})
        2'b10:   cnt_r <= cnt_r + 2'd1;
        2'b01:   cnt_r <= cnt_r - 2'd1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n) cnt_r != 2'd3)
    else $error("command queue occupancy out of range");

endmodule

>>> rtl/core/gfbr_back.sv
// Back end: executes commands against the identifier store and drives the
// result register. Uses gfbr_pkg; fed by gfbr_cmd_fifo.
module gfbr_back import gfbr_pkg::*; #(
  parameter int QUEUE_DEPTH = 64
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      cmd_valid,
  input  cmd_t      cmd_data,
  output logic      cmd_pop,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

  logic [ID_W-1:0]    mem [QUEUE_DEPTH];
  logic [ID_W-1:0]    rdata_r;

  back_state_t        state_r, state_nxt;
  logic [AW-1:0]      head_r, head_nxt;
  logic [AW-1:0]      tail_r, tail_nxt;
  logic [BURST_W-1:0] rem_r, rem_nxt;
  logic [WAIT_W-1:0]  wait_r, wait_nxt;
  logic               out_valid_r, out_valid_nxt;
  out_item_t          out_data_r, out_data_nxt;

  logic               load_ok;
  logic               out_load;
  logic               rd_en;
  logic               wr_en;

  assign load_ok   = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  function automatic logic [AW-1:0] next_slot(input logic [AW-1:0] p);
    next_slot = (p == AW'(QUEUE_DEPTH - 1)) ? '0 : p + AW'(1);
  endfunction

  // Sequence commands: single results load at once, a release drains one
  // entry per beat with the store read running one step ahead
  always_comb begin
    state_nxt    = state_r;
    head_nxt     = head_r;
    tail_nxt     = tail_r;
    rem_nxt      = rem_r;
    wait_nxt     = wait_r;
    out_data_nxt = out_data_r;
    out_load     = 1'b0;
    cmd_pop      = 1'b0;
    rd_en        = 1'b0;
    wr_en        = 1'b0;
    unique case (state_r)
      BK_IDLE: begin
        if (cmd_valid) begin
          if (cmd_data.op == KIND_RELEASED) begin
            cmd_pop   = 1'b1;
            rd_en     = 1'b1;
            head_nxt  = next_slot(head_r);
            rem_nxt   = cmd_data.count_n;
            wait_nxt  = cmd_data.waiting;
            state_nxt = BK_RELEASE;
          end else if (load_ok) begin
            cmd_pop                = 1'b1;
            out_load               = 1'b1;
            out_data_nxt.kind      = cmd_data.op;
            out_data_nxt.item_id   = cmd_data.id;
            out_data_nxt.gate_open = cmd_data.gate_after;
            out_data_nxt.waiting   = cmd_data.waiting;
            out_data_nxt.last      = 1'b1;
            if (cmd_data.op == KIND_QUEUED) begin
              wr_en    = 1'b1;
              tail_nxt = next_slot(tail_r);
            end
          end
        end
      end
      BK_RELEASE: begin
        if (load_ok) begin
          out_load               = 1'b1;
          out_data_nxt.kind      = KIND_RELEASED;
          out_data_nxt.item_id   = rdata_r;
          out_data_nxt.gate_open = 1'b0;
          out_data_nxt.waiting   = wait_r - WAIT_W'(1);
          out_data_nxt.last      = (rem_r == BURST_W'(1));
          wait_nxt               = wait_r - WAIT_W'(1);
          rem_nxt                = rem_r - BURST_W'(1);
          if (rem_r == BURST_W'(1)) begin
            state_nxt = BK_IDLE;
          end else begin
            rd_en    = 1'b1;
            head_nxt = next_slot(head_r);
          end
        end
      end
      default: state_nxt = BK_IDLE;
    endcase
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  // Identifier store: write at the tail, registered read at the head
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[tail_r] <= cmd_data.id;
    end
    if (rd_en) begin
      rdata_r <= mem[head_r];
    end
  end

  // Hold the result payload until the next load
  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data_r <= out_data_nxt;
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_IDLE;
      head_r      <= '0;
      tail_r      <= '0;
      rem_r       <= '0;
      wait_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      rem_r       <= rem_nxt;
      wait_r      <= wait_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  a_rem_live: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == BK_RELEASE |-> rem_r != '0)
    else $error("release burst running with nothing left to drain");

  a_burst_end: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == BK_RELEASE && load_ok && rem_r == BURST_W'(1)) |=> state_r == BK_IDLE)
    else $error("release burst did not finish after its last beat");

  a_no_pop_mid_burst: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == BK_RELEASE |-> !cmd_pop && !wr_en)
    else $error("command taken while a release burst is running");

endmodule

>>> rtl/core/gated_fifo_burst_release.sv
// Gated FIFO with burst release.
// Input beats (in_valid/in_ready, in_data) carry either an arrival with a
// vehicle identifier or a toggle of the gate. Each result beat (out_valid/
// out_ready, out_data) reports passed, queued, dropped, released, closed or
// opened-with-none, with the gate state, the waiting count and a last flag.
// cfg_valid/cfg_data write burst_size; cfg_ready is always high, and writes
// should only be made while the block is idle.
// A result is taken from the command queue into the result register; a
// release burst first reads the store, then shows one identifier per cycle
// while the receiver accepts. Arrivals and closing toggles sustain one beat
// per cycle while the receiver accepts; a toggle that releases identifiers
// holds the back end for its burst, bounded by the single store read port.
// A two-entry command queue sits between front and back, so input beats keep
// being accepted while a burst drains until that queue fills.
// Reset (rst_n low, synchronous) empties the FIFO, closes the gate and sets
// burst_size to zero; the store is not cleared, as entries are only read
// after being written. When the receiver stalls, the result is held and the
// back end, then the command queue, then in_ready back up in turn.
// Depends on gfbr_pkg, gfbr_front, gfbr_cmd_fifo and gfbr_back.
module gated_fifo_burst_release import gfbr_pkg::*; #(
  parameter int QUEUE_DEPTH = 64
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  in_item_t           in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output out_item_t          out_data,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [BURST_W-1:0] cfg_data
);

  logic cmd_push;
  logic cmd_full;
  logic cmd_pop;
  logic cmd_valid;
  cmd_t cmd_in;
  cmd_t cmd_out;

  assign cfg_ready = 1'b1;

  gfbr_front #(
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .cfg_valid(cfg_valid),
    .cfg_data (cfg_data),
    .cmd_full (cmd_full),
    .cmd_push (cmd_push),
    .cmd_data (cmd_in)
  );

  gfbr_cmd_fifo u_cmd_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (cmd_push),
    .push_data(cmd_in),
    .full     (cmd_full),
    .pop      (cmd_pop),
    .cmd_valid(cmd_valid),
    .cmd_data (cmd_out)
  );

  gfbr_back #(
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd_valid(cmd_valid),
    .cmd_data (cmd_out),
    .cmd_pop  (cmd_pop),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

endmodule
